/* hw/rtl/hfa_pkg.sv */
`default_nettype none

package hfa_pkg;

	// Fixed field widths
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned BASE_W   = 12;
	localparam int unsigned SIZE_W   = 13;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned POLICY_W = 2;

	// Memory size the free total saturates at (fits in SIZE_W)
	localparam int unsigned MEM_BYTES = 4096;

	// Default table depth
	localparam int unsigned MAX_HOLES_DEF = 64;

	// Configuration port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic        REG_FIT_POLICY = 1'b0;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_APPEND  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd2;

	// Fit policies (anything else behaves as first fit)
	localparam logic [POLICY_W-1:0] FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] WORST = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_COMPACT = 2'd1;
	localparam logic [STAT_W-1:0] ST_OOM     = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BASE_W-1:0] hole_base;
		logic [SIZE_W-1:0] hole_size;
		logic [SIZE_W-1:0] req_size;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BASE_W-1:0] alloc_base;
		logic [SIZE_W-1:0] free_bytes;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} hfa_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;    // latch incoming request
		logic exec;      // apply clear / append
		logic scan_run;  // walk the hole table
		logic out_load;  // move result into output register
	} hfa_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} hfa_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/hfa_ram.sv */
`default_nettype none

module hfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/hfa_dp.sv */
`default_nettype none

module hfa_dp
	import hfa_pkg::*;
#(
	parameter int unsigned MAX_HOLES = MAX_HOLES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire in_item_t         in_data,
	input  wire  [POLICY_W-1:0]   fit_policy,
	input  wire hfa_cmd_t         cmd,
	output hfa_stat_t             stat,
	input  wire                   out_stall,
	output logic                  out_valid,
	output out_item_t             out_data
);

	localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);
	localparam int unsigned IDX_W = $clog2(MAX_HOLES);
	localparam int unsigned ENT_W = BASE_W + SIZE_W;
	localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_HOLES);
	localparam logic [SIZE_W:0]   MEM_SAT = (SIZE_W+1)'(MEM_BYTES);

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [BASE_W-1:0] hbase_q;
	logic [SIZE_W-1:0] hsize_q;
	logic [SIZE_W-1:0] req_q;

	// table state
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] free_total_q;
	logic              full_q;

	// scan state
	logic [CNT_W-1:0]  scan_idx_q;
	logic              rd_vld_s1;
	logic              found_q;
	logic [SIZE_W-1:0] pick_size_q;
	logic [BASE_W-1:0] pick_base_q;

	// output register
	logic              out_valid_q;
	out_item_t         out_q;

	logic              tbl_full;
	logic              ram_we;
	logic [ENT_W-1:0]  ram_rdata;
	logic [BASE_W-1:0] rd_base;
	logic [SIZE_W-1:0] rd_size;
	logic              issue;
	logic              fits;
	logic              take;
	logic [SIZE_W:0]   sum;
	out_item_t         res;

	assign tbl_full = (count_q >= MAX_CNT);
	assign ram_we   = cmd.exec && (func_q == FN_APPEND) && !tbl_full;
	assign sum      = {1'b0, free_total_q} + {1'b0, hsize_q};

	hfa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_HOLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({hbase_q, hsize_q}),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_base = ram_rdata[ENT_W-1:SIZE_W];
	assign rd_size = ram_rdata[SIZE_W-1:0];
	assign issue   = cmd.scan_run && (scan_idx_q < count_q);
	assign fits    = rd_vld_s1 && (req_q <= rd_size);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy == BEST) begin
				take = (rd_size < pick_size_q);
			end else if (fit_policy == WORST) begin
				take = (rd_size > pick_size_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= in_data.func;
			hbase_q <= in_data.hole_base;
			hsize_q <= in_data.hole_size;
			req_q   <= in_data.req_size;
		end
		if (take) begin
			pick_size_q <= rd_size;
			pick_base_q <= rd_base;
		end
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			free_total_q <= '0;
			full_q       <= 1'b0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.accept) begin
				full_q     <= 1'b0;
				found_q    <= 1'b0;
				scan_idx_q <= '0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				case (func_q)
					FN_CLEAR: begin
						count_q      <= '0;
						free_total_q <= '0;
					end
					FN_APPEND: begin
						if (tbl_full) begin
							full_q <= 1'b1;
						end else begin
							count_q      <= count_q + 1'b1;
							free_total_q <= (sum > MEM_SAT) ? MEM_SAT[SIZE_W-1:0]
							                                : sum[SIZE_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res.status     = ST_OK;
		res.alloc_base = '0;
		res.free_bytes = free_total_q;
		case (func_q)
			FN_APPEND: begin
				if (full_q) begin
					res.status = ST_FULL;
				end
			end
			FN_REQUEST: begin
				if (found_q) begin
					res.alloc_base = pick_base_q;
				end else if (req_q <= free_total_q) begin
					res.status = ST_COMPACT;
				end else begin
					res.status = ST_OOM;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.scan_done = cmd.scan_run && !issue && !rd_vld_s1;
	assign stat.out_free  = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("hole count above table depth");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= MEM_SAT[SIZE_W-1:0])
		else $error("free total above memory size");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (req_q <= pick_size_q))
		else $error("picked hole smaller than request");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

/* hw/rtl/hfa_ctrl.sv */
`default_nettype none

module hfa_ctrl
	import hfa_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire            in_req,
	input  wire hfa_stat_t stat,
	output logic           in_stall,
	output hfa_cmd_t       cmd
);

	hfa_state_t state_q;
	hfa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = in_req ? ST_SCAN : ST_EXEC;
				end
			end
			ST_EXEC: state_nxt = ST_FINISH;
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.accept   = 1'b0;
		cmd.exec     = 1'b0;
		cmd.scan_run = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EXEC:   cmd.exec     = 1'b1;
			ST_SCAN:   cmd.scan_run = 1'b1;
			ST_FINISH: cmd.out_load = stat.out_free;
			default: begin
			end
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_SCAN || state_q == ST_EXEC))
		else $error("accepted request did not start work");

	a_exec_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == ST_FINISH))
		else $error("table update not followed by finish");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE))
		else $error("result load did not return to idle");

endmodule

`default_nettype wire

/* hw/rtl/hole_fit_allocator.sv */
// Free-hole table with first / best / worst fit allocation.
//
// Input channel (in_valid, in_stall, in_data): each request carries func.
//   Clear empties the table and the free total; append, if not full, stores
//   one hole (base, size) and adds its size to the free total, saturating
//   at memory size; request scans the table for a hole of at least req_size.
// Output channel (out_valid, out_stall, out_data): one result per request
//   with status, alloc_base and the free total after the operation.
// The fit policy register sits at byte address 0 of the APB port.
// Timing: one request at a time. Clear and append go through accept, table
//   update and result load. A request goes through accept, the scan and
//   result load: the scan reads one table entry per cycle from the hole RAM
//   with registered read, then waits out the read and sees the scan end.
//   The result shows in the cycle after the load.
// The finished result sits in an output register, so the block takes the
//   next request while that result waits. A stalled result holds; a second
//   result waits in the finish step until the register frees up.
// Reset empties the table, zeroes the free total and sets first fit. Hole
//   entries are not cleared: only entries below the hole count are read.
`default_nettype none

module hole_fit_allocator
	import hfa_pkg::*;
#(
	parameter int unsigned MAX_HOLES = MAX_HOLES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// request channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire in_item_t      in_data,
	// result channel
	output logic               out_valid,
	input  wire                out_stall,
	output out_item_t          out_data,
	// APB configuration port
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [POLICY_W-1:0] fit_policy_q;
	logic                cfg_wr;
	logic                in_req;
	hfa_cmd_t            cmd;
	hfa_stat_t           stat;

	// Registers are word-spaced; paddr[2] selects the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= FIRST;
		end else if (cfg_wr && (paddr[2] == REG_FIT_POLICY)) begin
			fit_policy_q <= pwdata[POLICY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FIT_POLICY) begin
			prdata = {{(PDATA_W-POLICY_W){1'b0}}, fit_policy_q};
		end
	end

	// Requests go to the scan; everything else is a single table update.
	assign in_req = (in_data.func == FN_REQUEST);

	hfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_req   (in_req),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	hfa_dp #(
		.MAX_HOLES(MAX_HOLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.fit_policy (fit_policy_q),
		.cmd        (cmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire
